// ----- hw/rtl/detection_box_overlay_unit_macros.svh -----
// Assertion macros shared by the overlay RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef DETECTION_BOX_OVERLAY_UNIT_MACROS_SVH
`define DETECTION_BOX_OVERLAY_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DBO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DBO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dbo_pkg.sv -----
// Shared types and constants of the detection box overlay unit.
// Used by dbo_cell and detection_box_overlay_unit; depends on nothing.
package dbo_pkg;

  localparam int OP_BITS    = 2;
  localparam int KIND_BITS  = 2;
  localparam int CAT_BITS   = 4;
  localparam int PIX_BITS   = 11;
  localparam int COLOR_BITS = 8;
  localparam int CFG_BITS   = 12;
  localparam int APB_DATA   = 32;
  localparam int APB_ADDR   = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PIXEL  = 2'd2
  } op_t;

  localparam logic [KIND_BITS-1:0] KIND_WAYBILL = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_LOGO    = 2'd1;

  localparam logic [CAT_BITS-1:0] CAT_YELLOW = 4'd1;
  localparam logic [CAT_BITS-1:0] CAT_BLUE   = 4'd2;

  localparam logic [COLOR_BITS-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_BITS-1:0] COLOR_NONE = 8'd0;

  // Register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RST = 12'd480;

  // Pixel packet travelling down the cell chain
  typedef struct packed {
    logic [PIX_BITS-1:0]   x;
    logic [PIX_BITS-1:0]   y;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
    logic                  in_img;
    logic                  logo_hit;
    logic [CAT_BITS-1:0]   logo_cat;
    logic                  way_hit;
  } pix_pkt_t;

endpackage

// ----- hw/rtl/detection_box_overlay_unit.sv -----
// Detection box overlay unit: top level with cell chain, box table control,
// output stage and APB registers. Depends on dbo_pkg, dbo_cell and the macros header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries three kinds of transfer, chosen by
//   in_operation: clear the box table, append one box, or one RGB888 pixel.
//   Result channel (out_valid/out_ready) returns one transfer per pixel, in order,
//   with the overlaid bytes and out_recoloured. Box transfers return nothing.
//   Each box lives in one cell of a chain of MAX_BOXES cells; a pixel walks the
//   chain one cell per cycle while the sink does not stall, and collects the winning logo and waybill hits.
//   A pixel result passes the MAX_BOXES cell registers and then the output register.
//   Throughput: one pixel per cycle while the receiver does not stall.
//   A clear or append is taken only once no pixel is left in the chain, so a box
//   transfer right after a pixel waits until it has left the last cell, longer while the sink stalls.
//   When the receiver stalls, the whole chain holds and in_ready drops; nothing
//   is lost or repeated.
//   Reset (rst_n, synchronous) empties the chain and the table count and loads
//   image_width = 640, image_height = 480. APB registers: image_width at 0x0,
//   image_height at 0x4; write them only while the unit is idle.
`include "detection_box_overlay_unit_macros.svh"

module detection_box_overlay_unit #(
  parameter int MAX_BOXES  = 16,
  parameter int BORDER_W   = 2,
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dbo_pkg::OP_BITS-1:0]          in_operation,
  input  logic signed [COORD_BITS-1:0]         in_box_left,
  input  logic signed [COORD_BITS-1:0]         in_box_top,
  input  logic signed [COORD_BITS-1:0]         in_box_right,
  input  logic signed [COORD_BITS-1:0]         in_box_bottom,
  input  logic [dbo_pkg::KIND_BITS-1:0]        in_box_kind,
  input  logic [dbo_pkg::CAT_BITS-1:0]         in_box_category,
  input  logic [dbo_pkg::PIX_BITS-1:0]         in_pixel_x,
  input  logic [dbo_pkg::PIX_BITS-1:0]         in_pixel_y,
  input  logic [dbo_pkg::COLOR_BITS-1:0]       in_pixel_blue,
  input  logic [dbo_pkg::COLOR_BITS-1:0]       in_pixel_green,
  input  logic [dbo_pkg::COLOR_BITS-1:0]       in_pixel_red,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dbo_pkg::COLOR_BITS-1:0]       out_blue,
  output logic [dbo_pkg::COLOR_BITS-1:0]       out_green,
  output logic [dbo_pkg::COLOR_BITS-1:0]       out_red,
  output logic                                 out_recoloured,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dbo_pkg::APB_ADDR-1:0]         paddr,
  input  logic [dbo_pkg::APB_DATA-1:0]         pwdata,
  output logic [dbo_pkg::APB_DATA-1:0]         prdata,
  output logic                                 pready
);

  localparam int TW = $clog2(MAX_BOXES + 1);

  // Configuration registers
  logic [dbo_pkg::CFG_BITS-1:0] width_r, height_r;
  logic                         cfg_wr;

  // Table count and chain
  logic [TW-1:0]             total_r, total_nxt;
  logic                      adv;
  logic                      chain_busy;
  logic                      in_xfer;
  logic                      is_pixel;
  logic                      do_append;
  logic [MAX_BOXES:0]        valid_chain;
  dbo_pkg::pix_pkt_t         pkt_chain [MAX_BOXES+1];
  logic [MAX_BOXES-1:0]      cell_valid;

  // Output stage
  logic                           out_valid_r;
  logic [dbo_pkg::COLOR_BITS-1:0] blue_r, green_r, red_r;
  logic [dbo_pkg::COLOR_BITS-1:0] blue_nxt, green_nxt, red_nxt;
  logic                           recol_r, recol_nxt;
  dbo_pkg::pix_pkt_t              last_pkt;

  // ---------------------------------------------------------------------------
  // APB registers: write on the access phase, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dbo_pkg::IMAGE_WIDTH_RST;
      height_r <= dbo_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == dbo_pkg::REG_IMAGE_WIDTH) begin
        width_r <= pwdata[dbo_pkg::CFG_BITS-1:0];
      end else begin
        height_r <= pwdata[dbo_pkg::CFG_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == dbo_pkg::REG_IMAGE_HEIGHT) begin
      prdata = dbo_pkg::APB_DATA'(height_r);
    end else begin
      prdata = dbo_pkg::APB_DATA'(width_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Input control: the chain advances unless a result waits on a stalled sink.
  // Box transfers wait for an empty chain so no pixel in flight sees a new table.
  // ---------------------------------------------------------------------------
  assign adv        = !out_valid_r || out_ready;
  assign chain_busy = |cell_valid;
  assign is_pixel   = (in_operation == dbo_pkg::OP_PIXEL);
  assign in_ready   = adv && (is_pixel || !chain_busy);
  assign in_xfer    = in_valid && in_ready;
  assign do_append  = in_xfer && (in_operation == dbo_pkg::OP_APPEND) &&
                      (total_r < TW'(MAX_BOXES));

  always_comb begin
    total_nxt = total_r;
    if (in_xfer && (in_operation == dbo_pkg::OP_CLEAR)) begin
      total_nxt = '0;
    end else if (do_append) begin
      total_nxt = total_r + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Chain head: pixel packet with nothing hit yet
  always_comb begin
    pkt_chain[0]          = '0;
    pkt_chain[0].x        = in_pixel_x;
    pkt_chain[0].y        = in_pixel_y;
    pkt_chain[0].blue     = in_pixel_blue;
    pkt_chain[0].green    = in_pixel_green;
    pkt_chain[0].red      = in_pixel_red;
    pkt_chain[0].in_img   = ({1'b0, in_pixel_x} < width_r) && ({1'b0, in_pixel_y} < height_r);
  end
  assign valid_chain[0] = in_xfer && is_pixel;

  // ---------------------------------------------------------------------------
  // Cell chain: cell i holds table entry i and is live while i < total
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    dbo_cell #(
      .COORD_BITS (COORD_BITS),
      .BORDER_W   (BORDER_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .active    (TW'(i) < total_r),
      .wr_en     (do_append && (total_r == TW'(i))),
      .wr_left   (in_box_left),
      .wr_top    (in_box_top),
      .wr_right  (in_box_right),
      .wr_bottom (in_box_bottom),
      .wr_kind   (in_box_kind),
      .wr_cat    (in_box_category),
      .in_valid  (valid_chain[i]),
      .in_pkt    (pkt_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_pkt   (pkt_chain[i+1])
    );
    assign cell_valid[i] = valid_chain[i+1];
  end

  // ---------------------------------------------------------------------------
  // Output stage: logo wins over waybill, pixels outside the image pass
  // ---------------------------------------------------------------------------
  assign last_pkt = pkt_chain[MAX_BOXES];

  always_comb begin
    blue_nxt  = last_pkt.blue;
    green_nxt = last_pkt.green;
    red_nxt   = last_pkt.red;
    recol_nxt = 1'b0;
    priority if (last_pkt.in_img && last_pkt.logo_hit) begin
      recol_nxt = 1'b1;
      priority if (last_pkt.logo_cat == dbo_pkg::CAT_YELLOW) begin
        blue_nxt  = dbo_pkg::COLOR_NONE;
        green_nxt = dbo_pkg::COLOR_FULL;
        red_nxt   = dbo_pkg::COLOR_FULL;
      end else if (last_pkt.logo_cat == dbo_pkg::CAT_BLUE) begin
        blue_nxt  = dbo_pkg::COLOR_FULL;
        green_nxt = dbo_pkg::COLOR_NONE;
        red_nxt   = dbo_pkg::COLOR_NONE;
      end else begin
        blue_nxt  = dbo_pkg::COLOR_NONE;
        green_nxt = dbo_pkg::COLOR_NONE;
        red_nxt   = dbo_pkg::COLOR_FULL;
      end
    end else if (last_pkt.in_img && last_pkt.way_hit) begin
      recol_nxt = 1'b1;
      blue_nxt  = dbo_pkg::COLOR_NONE;
      green_nxt = dbo_pkg::COLOR_FULL;
      red_nxt   = dbo_pkg::COLOR_NONE;
    end else begin
      recol_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_chain[MAX_BOXES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
      recol_r <= recol_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blue       = blue_r;
  assign out_green      = green_r;
  assign out_red        = red_r;
  assign out_recoloured = recol_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DBO_ASSERT_NOW(a_box_only_when_drained, in_xfer && !is_pixel, !chain_busy, "box transfer with pixels in chain")
  `DBO_ASSERT_NOW(a_total_in_range, 1'b1, total_r <= TW'(MAX_BOXES), "box count past capacity")
  `DBO_ASSERT_NEXT(a_full_append_ignored, in_xfer && (in_operation == dbo_pkg::OP_APPEND) && (total_r == TW'(MAX_BOXES)), total_r == TW'(MAX_BOXES), "append changed a full table")
  `DBO_ASSERT_NEXT(a_chain_holds_on_stall, out_valid_r && !out_ready, $stable(cell_valid), "chain moved while sink stalled")
  `DBO_ASSERT_NOW(a_no_input_on_stall, out_valid_r && !out_ready, !in_ready, "input taken while sink stalled")

endmodule

// ----- hw/rtl/dbo_cell.sv -----
// One box cell of the overlay chain: holds a box and tests the passing pixel.
// Depends on dbo_pkg.
module dbo_cell #(
  parameter int COORD_BITS = 12,
  parameter int BORDER_W   = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                active,
  input  logic                                wr_en,
  input  logic signed [COORD_BITS-1:0]        wr_left,
  input  logic signed [COORD_BITS-1:0]        wr_top,
  input  logic signed [COORD_BITS-1:0]        wr_right,
  input  logic signed [COORD_BITS-1:0]        wr_bottom,
  input  logic [dbo_pkg::KIND_BITS-1:0]       wr_kind,
  input  logic [dbo_pkg::CAT_BITS-1:0]        wr_cat,
  input  logic                                in_valid,
  input  dbo_pkg::pix_pkt_t                   in_pkt,
  output logic                                out_valid,
  output dbo_pkg::pix_pkt_t                   out_pkt
);

  localparam int CW = ((COORD_BITS > dbo_pkg::PIX_BITS) ? COORD_BITS : dbo_pkg::PIX_BITS) + 2;

  logic signed [COORD_BITS-1:0]   left_r, top_r, right_r, bottom_r;
  logic [dbo_pkg::KIND_BITS-1:0]  kind_r;
  logic [dbo_pkg::CAT_BITS-1:0]   cat_r;
  logic                           valid_r;
  dbo_pkg::pix_pkt_t              pkt_r;
  dbo_pkg::pix_pkt_t              pkt_nxt;

  logic signed [CW-1:0] x_s, y_s, l_s, t_s, r_s, b_s, lw_s;
  logic xin, yin, border, drawable, hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_r   <= wr_left;
      top_r    <= wr_top;
      right_r  <= wr_right;
      bottom_r <= wr_bottom;
      kind_r   <= wr_kind;
      cat_r    <= wr_cat;
    end
  end

  always_comb begin
    x_s  = $signed({{(CW-dbo_pkg::PIX_BITS){1'b0}}, in_pkt.x});
    y_s  = $signed({{(CW-dbo_pkg::PIX_BITS){1'b0}}, in_pkt.y});
    l_s  = CW'(left_r);
    t_s  = CW'(top_r);
    r_s  = CW'(right_r);
    b_s  = CW'(bottom_r);
    lw_s = CW'(BORDER_W - 1);
    xin  = (x_s >= l_s) && (x_s <= r_s);
    yin  = (y_s >= t_s) && (y_s <= b_s);
    border = (xin && (y_s >= t_s) && (y_s <= t_s + lw_s)) ||
             (xin && (y_s >= b_s - lw_s) && (y_s <= b_s)) ||
             (yin && (x_s >= l_s) && (x_s <= l_s + lw_s)) ||
             (yin && (x_s >= r_s - lw_s) && (x_s <= r_s));
    drawable = (kind_r == dbo_pkg::KIND_WAYBILL) || (kind_r == dbo_pkg::KIND_LOGO);
    hit      = active && drawable && border;

    // Later cell overwrites: later box wins within a kind
    pkt_nxt = in_pkt;
    if (hit && (kind_r == dbo_pkg::KIND_LOGO)) begin
      pkt_nxt.logo_hit = 1'b1;
      pkt_nxt.logo_cat = cat_r;
    end
    if (hit && (kind_r == dbo_pkg::KIND_WAYBILL)) begin
      pkt_nxt.way_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pkt   = pkt_r;

endmodule
